// File: rtl/core/assert_macros.svh
// assertion helpers used by the bound checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DBAM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dbam assertion failed");

// next-cycle implication
`define DBAM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dbam assertion failed");

`endif

// File: rtl/core/dbam_pkg.sv
package dbam_pkg;

   localparam int MAX_TRACKS      = 40;
   localparam int ZONE_LAST_TRACK = 40;
   localparam int ADDR_W          = $clog2(MAX_TRACKS);
   localparam int TRACK_W         = 6;
   localparam int SECTOR_W        = 5;
   localparam int BITMAP_W        = 24;
   localparam int COUNT_W         = 10;
   localparam int TOP_W           = 7;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 10'd767;

   typedef enum logic [2:0] {
      REQ_LOAD  = 3'd0,
      REQ_TEST  = 3'd1,
      REQ_COUNT = 3'd2,
      REQ_TOTAL = 3'd3,
      REQ_FIND  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_TRACK  = 2'd1,
      ST_BAD_SECTOR = 2'd2,
      ST_DISK_FULL  = 2'd3
   } status_type;

   localparam logic CSR_LAST_TRACK = 1'b0;
   localparam logic CSR_DIR_TRACK  = 1'b1;

   typedef struct packed {
      logic [1:0]          status;
      logic                is_free;
      logic [COUNT_W-1:0]  free_count;
      logic [TRACK_W-1:0]  found_track;
      logic [SECTOR_W-1:0] found_sector;
   } result_type;

   // zone table: sectors per track
   function automatic logic [SECTOR_W-1:0] sectors_of(input logic [TRACK_W-1:0] t);
      logic [SECTOR_W-1:0] n;
      n = '0;
      if (t >= 6'd1 && t <= 6'd17) begin
         n = 5'd21;
      end else if (t >= 6'd18 && t <= 6'd24) begin
         n = 5'd19;
      end else if (t >= 6'd25 && t <= 6'd30) begin
         n = 5'd18;
      end else if (t >= 6'd31 && t <= 6'(ZONE_LAST_TRACK)) begin
         n = 5'd17;
      end
      return n;
   endfunction

   function automatic logic [BITMAP_W-1:0] live_mask(input logic [SECTOR_W-1:0] n);
      return (BITMAP_W'(1) << n) - BITMAP_W'(1);
   endfunction

   function automatic logic [SECTOR_W-1:0] pop24(input logic [BITMAP_W-1:0] v);
      logic [SECTOR_W-1:0] c;
      c = '0;
      for (int i = 0; i < BITMAP_W; i++) begin
         c = c + SECTOR_W'(v[i]);
      end
      return c;
   endfunction

   function automatic logic [SECTOR_W-1:0] first_set(input logic [BITMAP_W-1:0] v);
      logic [SECTOR_W-1:0] q;
      q = '0;
      for (int i = BITMAP_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            q = SECTOR_W'(i);
         end
      end
      return q;
   endfunction

endpackage

// File: rtl/core/dbam_req_if.sv
interface dbam_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [5:0]  track;
   logic [4:0]  sector;
   logic [23:0] bitmap;

   modport source (output valid, req_type, track, sector, bitmap, input ready);
   modport sink (input valid, req_type, track, sector, bitmap, output ready);
endinterface

// File: rtl/core/dbam_rsp_if.sv
interface dbam_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       is_free;
   logic [9:0] free_count;
   logic [5:0] found_track;
   logic [4:0] found_sector;

   modport source (output valid, status, is_free, free_count, found_track, found_sector,
                   input ready);
   modport sink (input valid, status, is_free, free_count, found_track, found_sector,
                 output ready);
endinterface

// File: rtl/core/dbam_ram.sv
module dbam_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/disk_block_allocation_map.sv
// load, bad track or sector and unknown requests: result register, then response register;
// test and track count read the ram once first; disk total and find free read one entry per track visited
// throughput: one transaction at a time, the next one is taken the cycle after the result
// moves to the response register; total and search walk one track entry per cycle (ram read)
// reset: per-entry valid bits clear at once so every sector reads used, no clearing pass;
// last track 35, directory track 18
module disk_block_allocation_map
   import dbam_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   dbam_req_if.sink     req_chan,
   dbam_rsp_if.source   rsp_chan,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [5:0]   csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   req_code_type          op_ff, op_in;
   logic [TRACK_W-1:0]    last_track_ff, dir_track_ff;
   logic [TRACK_W-1:0]    idx_ff, idx_in;
   logic                  above_ff, above_in;
   logic                  done_ff, done_in;
   logic                  pend_ff, pend_in;
   logic [TRACK_W-1:0]    pend_trk_ff, pend_trk_in;
   logic [SECTOR_W-1:0]   sec_ff, sec_in;
   logic [COUNT_W-1:0]    acc_ff, acc_in;
   result_type            res_ff, res_in;
   result_type            rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MAX_TRACKS-1:0] entry_valid_ff, entry_valid_in;
   logic                  rd_valid_ff;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
   logic [BITMAP_W-1:0]   ram_rdata;

   logic [TOP_W-1:0]      top_trk;
   logic                  req_accept, req_ok, req_sec_ok;
   logic [7:0]            cur_k;
   logic                  cur_ok;
   logic [BITMAP_W-1:0]   live;
   logic [SECTOR_W-1:0]   live_pop;
   logic                  finish;

   dbam_ram #(.WIDTH(BITMAP_W), .DEPTH(MAX_TRACKS)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_chan.bitmap),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // highest usable track
   always_comb begin
      top_trk = {1'b0, last_track_ff};
      if (top_trk > TOP_W'(ZONE_LAST_TRACK)) top_trk = TOP_W'(ZONE_LAST_TRACK);
      if (top_trk > TOP_W'(MAX_TRACKS)) top_trk = TOP_W'(MAX_TRACKS);
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_ok         = (req_chan.track != '0) && ({1'b0, req_chan.track} <= top_trk);
   assign req_sec_ok     = req_chan.sector < sectors_of(req_chan.track);

   // scan track: ascending for totals, mirrored around the directory for search
   always_comb begin
      if (op_ff == REQ_TOTAL) begin
         cur_k = {2'b00, idx_ff};
      end else if (above_ff) begin
         cur_k = {2'b00, dir_track_ff} + {2'b00, idx_ff};
      end else begin
         cur_k = {2'b00, dir_track_ff} - {2'b00, idx_ff};
      end
   end

   assign cur_ok   = !cur_k[7] && (cur_k != '0) && (cur_k[6:0] <= top_trk);
   assign live     = (rd_valid_ff ? ram_rdata : '0) & live_mask(sectors_of(pend_trk_ff));
   assign live_pop = pop24(live);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      above_in       = above_ff;
      done_in        = done_ff;
      pend_in        = 1'b0;
      pend_trk_in    = pend_trk_ff;
      sec_in         = sec_ff;
      acc_in         = acc_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      entry_valid_in = entry_valid_ff;
      ram_we         = 1'b0;
      ram_waddr      = ADDR_W'(req_chan.track - 6'd1);
      ram_raddr      = '0;
      finish         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_code_type'(req_chan.req_type);
               sec_in   = req_chan.sector;
               res_in   = '0;
               idx_in   = 6'd1;
               above_in = 1'b0;
               done_in  = 1'b0;
               acc_in   = '0;
               state_in = S_RESP;
               case (req_code_type'(req_chan.req_type))
                  REQ_LOAD: begin
                     if (req_ok) begin
                        ram_we = 1'b1;
                        entry_valid_in[ram_waddr] = 1'b1;
                     end else begin
                        res_in.status = ST_BAD_TRACK;
                     end
                  end
                  REQ_TEST, REQ_COUNT: begin
                     if (!req_ok) begin
                        res_in.status = ST_BAD_TRACK;
                     end else if (req_chan.req_type == REQ_TEST && !req_sec_ok) begin
                        res_in.status = ST_BAD_SECTOR;
                     end else begin
                        ram_raddr   = ADDR_W'(req_chan.track - 6'd1);
                        pend_in     = 1'b1;
                        pend_trk_in = req_chan.track;
                        done_in     = 1'b1;
                        state_in    = S_SCAN;
                     end
                  end
                  REQ_TOTAL, REQ_FIND: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // evaluate the entry read last cycle
            if (pend_ff) begin
               case (op_ff)
                  REQ_TEST: begin
                     res_in.is_free = live[sec_ff];
                     finish = 1'b1;
                  end
                  REQ_COUNT: begin
                     res_in.free_count = COUNT_W'(live_pop);
                     finish = 1'b1;
                  end
                  REQ_TOTAL: begin
                     if (pend_trk_ff != dir_track_ff) begin
                        acc_in = acc_ff + COUNT_W'(live_pop);
                     end
                  end
                  REQ_FIND: begin
                     if (live != '0) begin
                        res_in.found_track  = pend_trk_ff;
                        res_in.found_sector = first_set(live);
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end

            // issue the next read while the range lasts
            if (!done_ff && cur_ok) begin
               ram_raddr   = ADDR_W'(cur_k[5:0] - 6'd1);
               pend_in     = 1'b1;
               pend_trk_in = cur_k[5:0];
               if (op_ff == REQ_TOTAL || above_ff) begin
                  idx_in = idx_ff + 6'd1;
               end
               above_in = (op_ff != REQ_TOTAL) && !above_ff;
            end else begin
               done_in = 1'b1;
            end

            // all reads drained
            if (done_ff && !pend_ff) begin
               finish = 1'b1;
               if (op_ff == REQ_TOTAL) begin
                  res_in.free_count = (acc_ff > COUNT_LIMIT) ? COUNT_LIMIT : acc_ff;
               end else if (op_ff == REQ_FIND) begin
                  res_in.status = ST_DISK_FULL;
               end
            end

            if (finish) begin
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
         done_ff        <= 1'b0;
         entry_valid_ff <= '0;
         last_track_ff  <= 6'd35;
         dir_track_ff   <= 6'd18;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         pend_ff        <= pend_in;
         done_ff        <= done_in;
         entry_valid_ff <= entry_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LAST_TRACK: last_track_ff <= csr_wdata;
               CSR_DIR_TRACK:  dir_track_ff  <= csr_wdata;
               default:        last_track_ff <= last_track_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      above_ff    <= above_in;
      pend_trk_ff <= pend_trk_in;
      sec_ff      <= sec_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      rd_valid_ff <= entry_valid_ff[ram_raddr];
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_ff.status;
   assign rsp_chan.is_free      = rsp_ff.is_free;
   assign rsp_chan.free_count   = rsp_ff.free_count;
   assign rsp_chan.found_track  = rsp_ff.found_track;
   assign rsp_chan.found_sector = rsp_ff.found_sector;

endmodule

// File: rtl/core/dbam_checker.sv
`include "assert_macros.svh"

module dbam_checker
   import dbam_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_is_free,
   input logic [9:0] rsp_free_count,
   input logic [5:0] rsp_found_track,
   input logic [4:0] rsp_found_sector
);

   // a stalled response stays up
   `DBAM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // one transaction in flight: no back-to-back accepts
   `DBAM_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // full disk reports no block
   `DBAM_ASSERT_IMP(a_full_no_block, clock, reset,
      rsp_valid && rsp_status == ST_DISK_FULL,
      rsp_found_track == '0 && rsp_found_sector == '0)

   // a free sector answer carries nothing else
   `DBAM_ASSERT_IMP(a_free_exclusive, clock, reset, rsp_valid && rsp_is_free,
      rsp_status == ST_OK && rsp_free_count == '0 && rsp_found_track == '0)

   // found block lies on a real track
   `DBAM_ASSERT_IMP(a_found_range, clock, reset, rsp_valid,
      rsp_found_track <= 6'(ZONE_LAST_TRACK) && rsp_found_sector <= 5'd20)

endmodule

bind disk_block_allocation_map dbam_checker u_dbam_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_is_free      (rsp_chan.is_free),
   .rsp_free_count   (rsp_chan.free_count),
   .rsp_found_track  (rsp_chan.found_track),
   .rsp_found_sector (rsp_chan.found_sector)
);

// File: sim/dbam_checker.sv
module dbam_scoreboard
   import dbam_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dbam_req_if        req_mon,
   dbam_rsp_if        rsp_mon,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata,
   output int         fail_count,
   output int         outstanding,
   output int         checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [BITMAP_W-1:0] bam_store [1:MAX_TRACKS];
   logic [TRACK_W-1:0]  cfg_last;
   logic [TRACK_W-1:0]  cfg_dir;
   result_type          awaited_results[$];

   function automatic int zone_sectors(input int t);
      if (t >= 1 && t <= 17) begin
         return 21;
      end else if (t >= 18 && t <= 24) begin
         return 19;
      end else if (t >= 25 && t <= 30) begin
         return 18;
      end else if (t >= 31 && t <= 40) begin
         return 17;
      end
      return 0;
   endfunction

   function automatic int highest_track();
      int top;
      top = int'(cfg_last);
      if (top > ZONE_LAST_TRACK) begin
         top = ZONE_LAST_TRACK;
      end
      if (top > MAX_TRACKS) begin
         top = MAX_TRACKS;
      end
      return top;
   endfunction

   function automatic bit track_in_range(input int t);
      return t >= 1 && t <= highest_track();
   endfunction

   // bits above the zone's sector count never count as free
   function automatic logic [BITMAP_W-1:0] usable_bits(input int t);
      int n;
      logic [BITMAP_W-1:0] mask;
      n = zone_sectors(t);
      mask = '0;
      for (int i = 0; i < n; i++) begin
         mask[i] = 1'b1;
      end
      return bam_store[t] & mask;
   endfunction

   function automatic result_type predict_response(input logic [2:0] kind, input int trk,
                                                    input int sec,
                                                    input logic [BITMAP_W-1:0] bits);
      result_type r;
      int d;
      int k;
      int q;
      int total;
      bit found;
      logic [BITMAP_W-1:0] live;
      r = '0;
      found = 0;
      total = 0;
      d = int'(cfg_dir);
      case (kind)
         REQ_LOAD: begin
            if (track_in_range(trk)) begin
               bam_store[trk] = bits;
            end else begin
               r.status = ST_BAD_TRACK;
            end
         end
         REQ_TEST: begin
            if (!track_in_range(trk)) begin
               r.status = ST_BAD_TRACK;
            end else if (sec >= zone_sectors(trk)) begin
               r.status = ST_BAD_SECTOR;
            end else begin
               live = usable_bits(trk);
               r.is_free = live[sec];
            end
         end
         REQ_COUNT: begin
            if (track_in_range(trk)) begin
               r.free_count = COUNT_W'($countones(usable_bits(trk)));
            end else begin
               r.status = ST_BAD_TRACK;
            end
         end
         REQ_TOTAL: begin
            for (int t = 1; t <= highest_track(); t++) begin
               if (t != d) begin
                  total += $countones(usable_bits(t));
               end
            end
            r.free_count = (total > int'(COUNT_LIMIT)) ? COUNT_LIMIT : COUNT_W'(total);
         end
         REQ_FIND: begin
            // walk outward from the directory track, below first, until out of range
            k = d - 1;
            while (!found && track_in_range(k)) begin
               live = usable_bits(k);
               if (live != '0) begin
                  q = 0;
                  while (!live[q]) begin
                     q++;
                  end
                  r.found_track = TRACK_W'(k);
                  r.found_sector = SECTOR_W'(q);
                  found = 1;
               end else if (k < d) begin
                  k = 2 * d - k;
               end else begin
                  k = 2 * d - k - 1;
               end
            end
            if (!found) begin
               r.status = ST_DISK_FULL;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int t = 1; t <= MAX_TRACKS; t++) begin
            bam_store[t] = '0;
         end
         cfg_last = 6'd35;
         cfg_dir = 6'd18;
         awaited_results.delete();
         fail_count = 0;
         outstanding = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_LAST_TRACK) begin
               cfg_last = csr_wdata;
            end else begin
               cfg_dir = csr_wdata;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_results.push_back(predict_response(req_mon.req_type, int'(req_mon.track),
                                                       int'(req_mon.sector), req_mon.bitmap));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected response transaction: expected none, actual status %0d",
                        $time, rsp_mon.status);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("status", want.status, rsp_mon.status);
               compare_field("is_free", want.is_free, rsp_mon.is_free);
               compare_field("free_count", want.free_count, rsp_mon.free_count);
               compare_field("found_track", want.found_track, rsp_mon.found_track);
               compare_field("found_sector", want.found_sector, rsp_mon.found_sector);
               checked++;
            end
         end
         outstanding = awaited_results.size();
      end
   end

endmodule

// File: sim/tb_disk_block_allocation_map.sv
module tb_disk_block_allocation_map
   import dbam_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int STALL_AT = 150;
   localparam int STALL_CYCLES = 400;
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [5:0] csr_wdata;

   int fail_count;
   int outstanding;
   int checked;
   int cycle_count;
   int rsp_taken;
   int settings_used;
   int cfg_last;
   bit no_idle;

   dbam_req_if req_chan ();
   dbam_rsp_if rsp_chan ();

   disk_block_allocation_map dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dbam_scoreboard checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = ~clock;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d transactions still awaited", cycle_count,
               outstanding);
      $display("FAILURE");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off
   initial begin
      int stall;
      bit held;
      held = 0;
      rsp_taken = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset) begin
            if (!held && rsp_taken == STALL_AT) begin
               held = 1;
               rsp_chan.ready = 1'b0;
               repeat (STALL_CYCLES) @(negedge clock);
            end
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
               rsp_chan.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_chan.ready = 1'b1;
            do @(posedge clock); while (!rsp_chan.valid);
            rsp_taken++;
         end
      end
   end

   task automatic send_request(input logic [2:0] kind, input int trk, input int sec,
                               input logic [BITMAP_W-1:0] bits);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.req_type = kind;
      req_chan.track = TRACK_W'(trk);
      req_chan.sector = SECTOR_W'(sec);
      req_chan.bitmap = bits;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input int value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = 6'(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [BITMAP_W-1:0] pick_bitmap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         return '0;
      end else if (pick < 50) begin
         return BITMAP_W'(1) << $urandom_range(0, BITMAP_W - 1);
      end else if (pick < 60) begin
         return '1;
      end
      return BITMAP_W'($urandom);
   endfunction

   task automatic random_traffic(input int n);
      int pick;
      int trk;
      int sec;
      logic [2:0] kind;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 29) == 0) begin
            no_idle = ~no_idle;
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            kind = REQ_LOAD;
         end else if (pick < 50) begin
            kind = REQ_TEST;
         end else if (pick < 65) begin
            kind = REQ_COUNT;
         end else if (pick < 77) begin
            kind = REQ_TOTAL;
         end else if (pick < 93) begin
            kind = REQ_FIND;
         end else begin
            kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
         end
         trk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, cfg_last);
         sec = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 20);
         send_request(kind, trk, sec, pick_bitmap());
      end
   endtask

   // new register setting, then a fresh mostly empty map and random traffic
   task automatic run_setting(input int last, input int dir, input int n);
      wait_idle();
      write_reg(CSR_LAST_TRACK, last);
      write_reg(CSR_DIR_TRACK, dir);
      cfg_last = last;
      settings_used++;
      for (int t = 1; t <= last; t++) begin
         send_request(REQ_LOAD, t, 0,
                      ($urandom_range(0, 9) < 7) ? '0 : BITMAP_W'(1) << $urandom_range(0, 23));
      end
      random_traffic(n);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_LAST_TRACK;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_LOAD;
      req_chan.track = '0;
      req_chan.sector = '0;
      req_chan.bitmap = '0;
      no_idle = 0;
      cfg_last = 35;
      settings_used = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corner cases on the reset setting: last track 35, directory 18
      send_request(REQ_FIND, 0, 0, '0);
      send_request(REQ_TOTAL, 0, 0, '0);
      send_request(REQ_LOAD, 0, 0, '1);
      send_request(REQ_LOAD, 36, 0, '1);
      send_request(REQ_LOAD, 63, 31, '1);
      send_request(REQ_LOAD, 1, 0, '1);
      send_request(REQ_LOAD, 35, 0, 24'h000001);
      send_request(REQ_LOAD, 17, 0, 24'h100000);
      send_request(REQ_LOAD, 24, 0, 24'h040000);
      send_request(REQ_TEST, 1, 20, '0);
      send_request(REQ_TEST, 1, 21, '0);
      send_request(REQ_TEST, 1, 31, '0);
      send_request(REQ_TEST, 35, 16, '0);
      send_request(REQ_TEST, 35, 17, '0);
      send_request(REQ_TEST, 0, 0, '0);
      send_request(REQ_COUNT, 1, 0, '0);
      send_request(REQ_COUNT, 63, 0, '0);
      send_request(REQ_COUNT, 18, 0, '0);
      send_request(REQ_TOTAL, 0, 0, '0);
      send_request(REQ_FIND, 0, 0, '0);
      send_request(REQ_LOAD, 17, 0, '0);
      send_request(REQ_FIND, 0, 0, '0);
      send_request(REQ_UNUSED_LO, 63, 31, '1);
      send_request(REQ_UNUSED_HI, 21, 7, 24'hA5A5A5);
      send_request(REQ_LOAD, 18, 0, '1);
      send_request(REQ_TOTAL, 0, 0, '0);

      run_setting(40, 2, 40);
      // directory above the last track: search finds nothing at once
      run_setting(35, 39, 40);
      run_setting(40, 39, 40);
      run_setting(37, 20, 40);

      // directory out of range and every sector free: total saturates
      wait_idle();
      write_reg(CSR_LAST_TRACK, 40);
      write_reg(CSR_DIR_TRACK, 63);
      cfg_last = 40;
      settings_used++;
      for (int t = 1; t <= 40; t++) begin
         send_request(REQ_LOAD, t, 0, '1);
      end
      send_request(REQ_TOTAL, 0, 0, '0);
      send_request(REQ_FIND, 0, 0, '0);
      random_traffic(40);

      run_setting(36, 18, 40);
      run_setting(35, 10, 40);
      run_setting(38, 30, 40);

      wait_idle();
      repeat (50) @(posedge clock);
      $display("checked %0d responses over %0d register settings, incl. a %0d-cycle stall",
               checked, settings_used, STALL_CYCLES);
      $display("covered bad tracks and sectors, empty and saturated maps, unused request codes");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
